>>> sv/pfs_pkg.sv
// Package for the palette frame sequencer: command codes and fixed field widths.
// No dependencies; imported by every module of the block.
`default_nettype none

package pfs_pkg;

  localparam int DATA_W    = 16;  // hold counts and colour words
  localparam int SLOT_W    = 6;   // vector_slot field
  localparam int WORD_W    = 4;   // word_slot and entry_index fields
  localparam int PAL_W     = 2;   // palette number
  localparam int BURST_MAX = 16;  // longest colour burst

  typedef enum logic [1:0] {
    CMD_HOLD    = 2'd0,
    CMD_COLOR   = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

endpackage

`default_nettype wire

>>> sv/pfs_table.sv
// Frame vector table: hold-count memory and colour-word memory.
// One write and one registered read port each; uses pfs_pkg.
`default_nettype none

module pfs_table import pfs_pkg::*; #(
  parameter int VECTORS = 64,
  parameter int ENTRIES = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   hold_we_i,
  input  wire logic [$clog2(VECTORS)-1:0]             hold_waddr_i,
  input  wire logic [DATA_W-1:0]                      hold_wdata_i,
  input  wire logic [$clog2(VECTORS)-1:0]             hold_raddr_i,
  output logic      [DATA_W-1:0]                      hold_rdata_o,
  input  wire logic                                   col_we_i,
  input  wire logic [$clog2(VECTORS*ENTRIES)-1:0]     col_waddr_i,
  input  wire logic [DATA_W-1:0]                      col_wdata_i,
  input  wire logic [$clog2(VECTORS*ENTRIES)-1:0]     col_raddr_i,
  output logic      [DATA_W-1:0]                      col_rdata_o
);

  logic [DATA_W-1:0] hold_mem [VECTORS];
  logic [DATA_W-1:0] col_mem  [VECTORS*ENTRIES];

  always_ff @(posedge clk_i) begin
    if (hold_we_i) begin
      hold_mem[hold_waddr_i] <= hold_wdata_i;
    end
    hold_rdata_o <= hold_mem[hold_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (col_we_i) begin
      col_mem[col_waddr_i] <= col_wdata_i;
    end
    col_rdata_o <= col_mem[col_raddr_i];
  end

endmodule

`default_nettype wire

>>> sv/pfs_seq.sv
// Sequencer for the palette frame sequencer: takes items, drives the table
// ports, reduces jump targets and steps through the colour burst. Uses pfs_pkg.
`default_nettype none

module pfs_seq import pfs_pkg::*; #(
  parameter int VECTORS = 64,
  parameter int ENTRIES = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  output logic                                        busy_o,
  input  wire logic [1:0]                             cmd_i,
  input  wire logic [SLOT_W-1:0]                      vector_slot_i,
  input  wire logic [WORD_W-1:0]                      word_slot_i,
  output logic                                        hold_we_o,
  output logic      [$clog2(VECTORS)-1:0]             hold_waddr_o,
  output logic      [$clog2(VECTORS)-1:0]             hold_raddr_o,
  input  wire logic [DATA_W-1:0]                      hold_rdata_i,
  output logic                                        col_we_o,
  output logic      [$clog2(VECTORS*ENTRIES)-1:0]     col_waddr_o,
  output logic      [$clog2(VECTORS*ENTRIES)-1:0]     col_raddr_o,
  input  wire logic [DATA_W-1:0]                      col_rdata_i,
  output logic                                        out_valid_o,
  output logic      [WORD_W-1:0]                      out_index_o,
  output logic                                        out_last_o
);

  localparam int VW    = $clog2(VECTORS);
  localparam int CW    = $clog2(VECTORS*ENTRIES);
  localparam int BURST = (ENTRIES < BURST_MAX) ? ENTRIES : BURST_MAX;
  // Reciprocal of VECTORS, rounded up; exact for every DATA_W-bit jump target.
  localparam int     RSH   = DATA_W + VW;
  localparam int     RCP_W = DATA_W + 2;
  localparam int     PRD_W = DATA_W + RCP_W;
  localparam longint RECIP = ((longint'(1) << RSH) + longint'(VECTORS) - longint'(1)) /
                             longint'(VECTORS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MOD,
    S_REFETCH,
    S_BURST
  } state_e;

  state_e             state_q, state_d;
  logic [VW-1:0]      nv_q, nv_d;
  logic [DATA_W-1:0]  fr_q, fr_d;
  logic [VW-1:0]      cur_q, cur_d;
  logic [DATA_W-1:0]  rem_q, rem_d;
  logic [DATA_W-1:0]  quo_q, quo_d;
  logic [WORD_W-1:0]  k_q, k_d;
  logic               out_valid_q, out_valid_d;
  logic [WORD_W-1:0]  out_k_q, out_k_d;

  logic               accept;
  cmd_e               cmd;
  logic [VW-1:0]      slot;
  logic [PRD_W-1:0]   quo_prod;
  logic [DATA_W-1:0]  quo_next;
  logic [DATA_W-1:0]  quo_mul;
  logic [VW-1:0]      tgt;
  logic [DATA_W-1:0]  reload;
  logic [VW-1:0]      cur_inc;

  // Reduce a narrow slot number modulo the table size by conditional subtraction.
  function automatic logic [VW-1:0] slot_mod(input logic [SLOT_W-1:0] s);
    int r;
    r = int'(s);
    for (int i = SLOT_W - 1; i >= 0; i--) begin
      if (r >= (VECTORS << i)) begin
        r = r - (VECTORS << i);
      end
    end
    return VW'(r);
  endfunction

  function automatic logic [CW-1:0] col_addr(input logic [VW-1:0] v,
                                             input logic [WORD_W-1:0] w);
    return CW'(CW'(v) * CW'(ENTRIES) + CW'(w));
  endfunction

  assign accept = start_i && (state_q == S_IDLE);
  assign cmd    = cmd_e'(cmd_i);
  assign slot   = slot_mod(vector_slot_i);

  // Table writes land at the transfer edge itself.
  assign hold_we_o    = accept && (cmd == CMD_HOLD);
  assign hold_waddr_o = slot;
  assign col_we_o     = accept && (cmd == CMD_COLOR) &&
                        (int'(word_slot_i) < ENTRIES);
  assign col_waddr_o  = col_addr(slot, word_slot_i);

  // Jump-target reduction: quotient by reciprocal multiplication, then the remainder.
  assign quo_prod = PRD_W'(col_rdata_i) * PRD_W'(RECIP);
  assign quo_next = DATA_W'(quo_prod >> RSH);
  assign quo_mul  = quo_q * DATA_W'(VECTORS);
  assign tgt      = VW'(rem_q - quo_mul);

  // Counter reload: negative and zero hold counts behave as one frame.
  assign reload  = ($signed(hold_rdata_i) < $signed(DATA_W'(1))) ? '0
                                                                 : hold_rdata_i - DATA_W'(1);
  assign cur_inc = (int'(cur_q) == VECTORS - 1) ? '0 : cur_q + VW'(1);

  always_comb begin
    state_d      = state_q;
    nv_d         = nv_q;
    fr_d         = fr_q;
    cur_d        = cur_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    k_d          = k_q;
    out_valid_d  = 1'b0;
    out_k_d      = out_k_q;
    hold_raddr_o = nv_q;
    col_raddr_o  = col_addr(nv_q, '0);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_RESTART: begin
              nv_d = '0;
              fr_d = '0;
            end
            CMD_TICK: begin
              if (fr_q != '0) begin
                fr_d = fr_q - DATA_W'(1);
              end else begin
                cur_d   = nv_q;
                state_d = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end

      S_FETCH: begin
        if (hold_rdata_i == '0) begin
          // Jump vector: colour word 0 names the target.
          rem_d   = col_rdata_i;
          quo_d   = quo_next;
          state_d = S_MOD;
        end else begin
          fr_d    = reload;
          nv_d    = cur_inc;
          k_d     = '0;
          state_d = S_BURST;
        end
      end

      S_MOD: begin
        cur_d        = tgt;
        hold_raddr_o = tgt;
        state_d      = S_REFETCH;
      end

      S_REFETCH: begin
        // The target is taken as it stands, even if it is a jump itself.
        fr_d    = reload;
        nv_d    = cur_inc;
        k_d     = '0;
        state_d = S_BURST;
      end

      S_BURST: begin
        col_raddr_o = col_addr(cur_q, k_q);
        out_valid_d = 1'b1;
        out_k_d     = k_q;
        k_d         = k_q + WORD_W'(1);
        if (int'(k_q) == BURST - 1) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nv_q        <= '0;
      fr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nv_q        <= nv_d;
      fr_q        <= fr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    k_q     <= k_d;
    out_k_q <= out_k_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_index_o = out_k_q;
  assign out_last_o  = (int'(out_k_q) == BURST - 1);

endmodule

`default_nettype wire

>>> sv/palette_frame_sequencer.sv
// Top level of the palette frame sequencer: palette register, table and sequencer.
// Depends on pfs_pkg, pfs_table and pfs_seq.
//
//   channel   handshake                  payload
//   -------   ------------------------   ----------------------------------------------
//   command   start_i / busy_o           cmd_i, vector_slot_i, word_slot_i, word_value_i
//   config    cfg_valid_i / cfg_ready_o  cfg_data_i (palette number)
//   result    res_valid_o (strobe)       palette_id_o, entry_index_o, color_value_o, last_o
//
// A write, restart or counting tick is taken at its transfer; busy_o stays low.
// A reloading tick holds busy_o high while it reads the hold memory and then reads its
// burst of BURST colours (BURST = min(ENTRIES, 16)); when it meets a jump vector it
// first reduces the jump target modulo VECTORS by reciprocal multiplication, then
// reads the hold memory again. Colours leave one per cycle, each in the cycle after
// its colour-memory read. Reset clears the vector index, frame counter and palette number;
// the tables are undefined until written. The receiver cannot stall the result strobe.
`default_nettype none

module palette_frame_sequencer import pfs_pkg::*; #(
  parameter int VECTORS = 64,
  parameter int ENTRIES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [SLOT_W-1:0] vector_slot_i,
  input  wire logic [WORD_W-1:0] word_slot_i,
  input  wire logic [DATA_W-1:0] word_value_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [PAL_W-1:0]  cfg_data_i,
  output logic                   res_valid_o,
  output logic      [PAL_W-1:0]  palette_id_o,
  output logic      [WORD_W-1:0] entry_index_o,
  output logic      [DATA_W-1:0] color_value_o,
  output logic                   last_o
);

  localparam int VW = $clog2(VECTORS);
  localparam int CW = $clog2(VECTORS*ENTRIES);

  logic [PAL_W-1:0]  pal_q;

  logic              hold_we;
  logic [VW-1:0]     hold_waddr;
  logic [VW-1:0]     hold_raddr;
  logic [DATA_W-1:0] hold_rdata;
  logic              col_we;
  logic [CW-1:0]     col_waddr;
  logic [CW-1:0]     col_raddr;
  logic [DATA_W-1:0] col_rdata;

  // Palette number: always ready; user must write it only while block is idle, unenforced.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pal_q <= cfg_data_i;
    end
  end

  pfs_table #(
    .VECTORS (VECTORS),
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk_i        (clk_i),
    .hold_we_i    (hold_we),
    .hold_waddr_i (hold_waddr),
    .hold_wdata_i (word_value_i),
    .hold_raddr_i (hold_raddr),
    .hold_rdata_o (hold_rdata),
    .col_we_i     (col_we),
    .col_waddr_i  (col_waddr),
    .col_wdata_i  (word_value_i),
    .col_raddr_i  (col_raddr),
    .col_rdata_o  (col_rdata)
  );

  pfs_seq #(
    .VECTORS (VECTORS),
    .ENTRIES (ENTRIES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .vector_slot_i (vector_slot_i),
    .word_slot_i   (word_slot_i),
    .hold_we_o     (hold_we),
    .hold_waddr_o  (hold_waddr),
    .hold_raddr_o  (hold_raddr),
    .hold_rdata_i  (hold_rdata),
    .col_we_o      (col_we),
    .col_waddr_o   (col_waddr),
    .col_raddr_o   (col_raddr),
    .col_rdata_i   (col_rdata),
    .out_valid_o   (res_valid_o),
    .out_index_o   (entry_index_o),
    .out_last_o    (last_o)
  );

  // Colour data comes straight from the registered memory read; tag it with the palette.
  assign palette_id_o  = pal_q;
  assign color_value_o = col_rdata;

endmodule

`default_nettype wire

>>> tb/tb_palette_frame_sequencer.sv
// Self-checking testbench for palette_frame_sequencer: commands, palette register and colour bursts.
// Depends on pfs_pkg and the palette_frame_sequencer RTL; the expected colours come from a
// behavioural frame-vector table held in the scoreboard class below.

module tb_palette_frame_sequencer;
  import pfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VECTORS   = 64;
  localparam int ENTRIES   = 16;
  localparam int BURST_LEN = (ENTRIES < BURST_MAX) ? ENTRIES : BURST_MAX;
  // Reloading tick: busy through fetch and burst, plus the modulo and refetch states on a jump.
  localparam int SETTLE_CYCLES = 1 + BURST_LEN + 2 + 4;
  // Live vectors: 0 to LIVE-2 and the last slot, so the index also wraps.
  localparam int LIVE = 5;
  localparam int HI_W = DATA_W - SLOT_W;
  // Vector just past the low live ones: always a jump back into the live set.
  localparam logic [SLOT_W-1:0] JUMP_VEC = SLOT_W'(LIVE - 1);

  typedef struct packed {
    logic [PAL_W-1:0]  pal;
    logic [WORD_W-1:0] idx;
    logic [DATA_W-1:0] colour;
    logic              last;
  } colour_beat_t;

  // Frame-vector table, sequencer state and the queue of colours still owed by the block.
  class palette_burst_model;
    logic [DATA_W-1:0] hold_tbl[VECTORS];
    logic [DATA_W-1:0] colour_tbl[VECTORS*ENTRIES];
    int                next_vec;
    logic [DATA_W-1:0] frames_left;
    logic [PAL_W-1:0]  palette;
    colour_beat_t      owed_colours[$];
    int failures, bursts, jumps, counting_ticks, restarts, palettes_seen;

    function new();
      next_vec    = 0;
      frames_left = '0;
      palette     = '0;
      failures = 0; bursts = 0; jumps = 0; counting_ticks = 0; restarts = 0;
      palettes_seen = 0;
    endfunction

    function void set_palette(logic [PAL_W-1:0] p);
      palette = p;
    endfunction

    function int pending();
      return owed_colours.size();
    endfunction

    // Apply one accepted command transfer and queue the colours it should produce.
    function void note_transfer(cmd_e cmd, logic [SLOT_W-1:0] vs, logic [WORD_W-1:0] ws,
                                logic [DATA_W-1:0] val);
      int                 vec;
      logic signed [15:0] hold;
      colour_beat_t       beat;
      case (cmd)
        CMD_HOLD: begin
          hold_tbl[int'(vs) % VECTORS] = val;
        end
        CMD_COLOR: begin
          if (int'(ws) < ENTRIES) colour_tbl[(int'(vs) % VECTORS) * ENTRIES + int'(ws)] = val;
        end
        CMD_RESTART: begin
          next_vec    = 0;
          frames_left = '0;
          restarts++;
        end
        default: begin
          if (frames_left != 0) begin
            frames_left = frames_left - 1'b1;
            counting_ticks++;
          end else begin
            vec      = next_vec % VECTORS;
            next_vec = (vec + 1) % VECTORS;
            hold     = hold_tbl[vec];
            // Zero hold: follow colour word 0 once; a second zero is not followed.
            if (hold == 0) begin
              vec      = int'(colour_tbl[vec * ENTRIES]) % VECTORS;
              next_vec = (vec + 1) % VECTORS;
              hold     = hold_tbl[vec];
              jumps++;
            end
            if (hold < 1) hold = 1;
            frames_left = 16'(hold - 1);
            for (int k = 0; k < BURST_LEN; k++) begin
              beat.pal    = palette;
              beat.idx    = WORD_W'(k);
              beat.colour = colour_tbl[vec * ENTRIES + k];
              beat.last   = (k == BURST_LEN - 1);
              owed_colours.push_back(beat);
            end
            bursts++;
            palettes_seen |= 1 << palette;
          end
        end
      endcase
    endfunction

    function void compare(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t ns: %s mismatch: expected %h actual %h", $time, what, want, got);
      end
    endfunction

    function void check_colour(logic [PAL_W-1:0] pal, logic [WORD_W-1:0] idx,
                               logic [DATA_W-1:0] colour, logic last);
      colour_beat_t want;
      if (owed_colours.size() == 0) begin
        failures++;
        $display("%0t ns: unexpected colour: expected none actual idx %h colour %h",
                 $time, idx, colour);
        return;
      end
      want = owed_colours.pop_front();
      compare("palette_id", DATA_W'(want.pal), DATA_W'(pal));
      compare("entry_index", DATA_W'(want.idx), DATA_W'(idx));
      compare("color_value", want.colour, colour);
      compare("last", DATA_W'(want.last), DATA_W'(last));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [1:0]        cmd_i = '0;
  logic [SLOT_W-1:0] vector_slot_i = '0;
  logic [WORD_W-1:0] word_slot_i = '0;
  logic [DATA_W-1:0] word_value_i = '0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [PAL_W-1:0]  cfg_data_i = '0;
  logic              res_valid_o;
  logic [PAL_W-1:0]  palette_id_o;
  logic [WORD_W-1:0] entry_index_o;
  logic [DATA_W-1:0] color_value_o;
  logic              last_o;

  palette_burst_model sb = new();
  int                 burst_left = 0;

  palette_frame_sequencer #(
    .VECTORS(VECTORS),
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .vector_slot_i(vector_slot_i),
    .word_slot_i  (word_slot_i),
    .word_value_i (word_value_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .res_valid_o  (res_valid_o),
    .palette_id_o (palette_id_o),
    .entry_index_o(entry_index_o),
    .color_value_o(color_value_o),
    .last_o       (last_o)
  );

  always #4 clk_i = ~clk_i;

  // Results cannot be held off: take every strobed colour at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_colour(palette_id_o, entry_index_o, color_value_o, last_o);
  end

  // Pace the sender in bursts: mostly short bursts with gaps of varying length, so that
  // gaps land on every phase of a reload; now and then a long burst with no gaps at all.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(4) == 0) begin
        burst_left = $urandom_range(60, 30);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(12, 1);
        gap        = $urandom_range(20, 1);
      end
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Offer one command and hold it until the block takes the transfer (start high, busy low).
  task automatic send(input cmd_e cmd, input logic [SLOT_W-1:0] vs,
                      input logic [WORD_W-1:0] ws, input logic [DATA_W-1:0] val);
    pace();
    start_i       <= 1'b1;
    cmd_i         <= cmd;
    vector_slot_i <= vs;
    word_slot_i   <= ws;
    word_value_i  <= val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_transfer(cmd, vs, ws, val);
  endtask

  // Drop start and wait until every owed colour has come out.
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Drain, then let a worst-case reload run out before touching the register.
  task automatic set_palette(input logic [PAL_W-1:0] p);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= p;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    sb.set_palette(p);
  endtask

  // Hold counts favour short holds, jumps and negatives; the extremes turn up rarely
  // since a long hold parks the sequencer until the next restart.
  function automatic logic [DATA_W-1:0] rand_hold();
    int r;
    r = $urandom_range(99);
    if (r < 20) return '0;
    if (r < 60) return DATA_W'($urandom_range(3, 1));
    if (r < 72) return 16'hFFFF - DATA_W'($urandom_range(3, 0));
    if (r < 75) return 16'h8000;
    if (r < 97) return DATA_W'($urandom_range(6, 4));
    if (r < 98) return 16'h7FFF;
    return DATA_W'($urandom);
  endfunction

  function automatic logic [SLOT_W-1:0] live_vec(input int j);
    return (j == LIVE - 1) ? SLOT_W'(VECTORS - 1) : SLOT_W'(j);
  endfunction

  function automatic logic [SLOT_W-1:0] rand_live();
    return live_vec(int'($urandom_range(LIVE - 1)));
  endfunction

  // Colour word 0 doubles as a jump target, so keep it on a live vector.
  function automatic logic [DATA_W-1:0] colour_word(input logic [WORD_W-1:0] w);
    if (w == '0) return {HI_W'($urandom), rand_live()};
    return DATA_W'($urandom);
  endfunction

  // Mostly ticks over a live table, with rewrites of holds and colours and the odd restart.
  task automatic run_random(input int n, input bit pause_midway);
    int                r;
    logic [SLOT_W-1:0] vs;
    logic [WORD_W-1:0] ws;
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain();
      r = $urandom_range(99);
      if (r < 52)
        send(CMD_TICK, SLOT_W'($urandom), WORD_W'($urandom), DATA_W'($urandom));
      else if (r < 62)
        send(CMD_HOLD, rand_live(), WORD_W'($urandom), rand_hold());
      else if (r < 92) begin
        vs = ($urandom_range(3) == 0) ? SLOT_W'($urandom) : rand_live();
        ws = WORD_W'($urandom);
        send(CMD_COLOR, vs, ws, colour_word(ws));
      end else
        send(CMD_RESTART, SLOT_W'($urandom), WORD_W'($urandom), DATA_W'($urandom));
    end
  endtask

  initial begin
    #2_000_000;
    $display("FAIL palette_frame_sequencer");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill the live vectors and the jump vector behind them: the block's stores are
    // undefined until written, and every fetch stays inside this set.
    for (int j = 0; j < LIVE; j++)
      send(CMD_HOLD, live_vec(j), WORD_W'($urandom), rand_hold());
    send(CMD_HOLD, JUMP_VEC, '0, '0);
    send(CMD_COLOR, JUMP_VEC, '0, colour_word('0));
    for (int j = 0; j < LIVE; j++)
      for (int w = 0; w < ENTRIES; w++)
        send(CMD_COLOR, live_vec(j), WORD_W'(w), colour_word(WORD_W'(w)));

    // Directed part, under the reset palette number.
    send(CMD_RESTART, '0, '0, '0);
    send(CMD_HOLD, 6'd0, 4'd0, 16'd2);
    send(CMD_TICK, '0, '0, '0);                 // reload from vector 0, counter to 1
    send(CMD_TICK, '1, '1, '1);                 // counting tick, no colours
    send(CMD_HOLD, 6'd1, 4'd0, 16'h0000);       // vector 1 becomes a jump
    send(CMD_COLOR, 6'd1, 4'd0, 16'hFFFF);      // target reduces to vector 63
    send(CMD_HOLD, 6'd63, 4'd15, 16'h8000);     // most negative hold acts as 1
    send(CMD_TICK, '0, '0, '0);                 // jump to 63, next index wraps to 0
    send(CMD_HOLD, 6'd0, 4'd0, 16'h0000);       // vector 0 jumps too
    send(CMD_COLOR, 6'd0, 4'd0, 16'h0042);      // to vector 2 (66 mod 64)
    send(CMD_HOLD, 6'd2, 4'd0, 16'h0000);       // jump target that is itself a jump
    send(CMD_TICK, '0, '0, '0);
    send(CMD_HOLD, 6'd3, 4'd0, 16'h7FFF);       // largest positive hold
    send(CMD_TICK, '0, '0, '0);
    send(CMD_TICK, '0, '0, '0);
    send(CMD_COLOR, 6'd63, 4'd15, 16'hFFFF);
    send(CMD_COLOR, 6'd63, 4'd0, 16'h0000);
    send(CMD_RESTART, '1, '1, '1);              // clear index and counter mid-hold
    send(CMD_TICK, '0, '0, '0);
    send(CMD_HOLD, 6'd3, 4'd0, 16'h0001);
    send(CMD_TICK, '0, '0, '0);
    send(CMD_TICK, '0, '0, '0);

    // Random phases, one per palette setting, starting with the highest.
    set_palette(2'd3);
    run_random(30, 1'b1);
    set_palette(2'd1);
    run_random(30, 1'b0);
    set_palette(2'd0);
    run_random(30, 1'b0);
    set_palette(2'd2);
    run_random(30, 1'b0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d colour bursts (%0d through jump vectors), %0d counting ticks,",
             sb.bursts, sb.jumps, sb.counting_ticks);
    $display("%0d restarts and palette mask %b.", sb.restarts, sb.palettes_seen[3:0]);
    if (sb.failures == 0)
      $display("PASS palette_frame_sequencer");
    else
      $display("FAIL palette_frame_sequencer");
    $finish;
  end

endmodule
